// ----- hdl/sparse_hint_decoder_checker_macros.svh -----
// Assertion helpers used by the checker file shd_checker.sv.
`ifndef SPARSE_HINT_DECODER_CHECKER_MACROS_SVH
`define SPARSE_HINT_DECODER_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shd check failed: %m");

// Next-cycle implication, disabled during reset.
`define SHD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shd check failed: %m");

`endif

// ----- hdl/shd_pkg.sv -----
package shd_pkg;

  localparam int MAX_POLYS_DEF      = 8;
  localparam int SECTION_SIZE_DEF   = 32;
  localparam int MAX_HINT_LIMIT_DEF = 176;

  localparam int SECS_PER_POLY = 8;

  // Configuration register map: register index is byte address bit 2.
  localparam int CFG_AW = 3;
  localparam logic CFG_IDX_NUM_POLYS = 1'b0;
  localparam logic CFG_IDX_MAX_HINTS = 1'b1;

  localparam logic [3:0] NUM_POLYS_RST = 4'd4;
  localparam logic [7:0] MAX_HINTS_RST = 8'd80;

  typedef struct packed {
    logic [3:0] num_polys;
    logic [7:0] max_hints;
  } cfg_t;

  // One position check request to the shared position unit.
  typedef struct packed {
    logic [5:0]        pos;
    logic              left_zero;
    logic signed [6:0] prev;
    logic [2:0]        sec_lo;
  } pos_req_t;

  typedef struct packed {
    logic       bad;
    logic [7:0] coeff;
  } pos_res_t;

endpackage

// ----- hdl/shd_stream_if.sv -----
interface shd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hint_byte;
  logic       last_byte;

  modport source (output valid, output hint_byte, output last_byte, input ready);
  modport sink (input valid, input hint_byte, input last_byte, output ready);
endinterface

interface shd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] poly_index;
  logic [7:0] coeff_index;
  logic       is_verdict;
  logic       verdict;
  logic       run_end;

  modport source (output valid, output poly_index, output coeff_index, output is_verdict,
                  output verdict, output run_end, input ready);
  modport sink (input valid, input poly_index, input coeff_index, input is_verdict,
                input verdict, input run_end, output ready);
endinterface

// ----- hdl/sparse_hint_decoder_checker.sv -----
// Hint field checker and decoder. Takes the hint field one byte per transfer
// (header byte with the used section count, then packed 4-bit section counts,
// then packed 6-bit positions) and returns one result transfer per set
// position (polynomial and coefficient index) plus a verdict result on the
// flagged last byte; on verdict 1 the positions of that field are to be
// dropped. One byte is worked on at a time and the input is not ready
// meanwhile. The byte that closes the counts also starts the positions
// (one read of the section count table). A position byte is decoded one
// position at a time, with a count table read for each empty section
// skipped, and then hands over the last pending result; the last byte adds
// the verdict result once the pending result is out. A
// result waiting in the output register does not hold off the next byte, but
// a stalled output holds the sequencer once a second result is ready.
// Configuration: num_polys at byte address 0, max_hints at byte address 4.
module sparse_hint_decoder_checker #(
  parameter int MAX_POLYS      = shd_pkg::MAX_POLYS_DEF,
  parameter int SECTION_SIZE   = shd_pkg::SECTION_SIZE_DEF,
  parameter int MAX_HINT_LIMIT = shd_pkg::MAX_HINT_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  shd_in_if.sink                     in_ch,
  shd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [shd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import shd_pkg::*;

  // Section count table: one row holds the two counts of one count byte.
  localparam int RAM_DEPTH = MAX_POLYS * SECS_PER_POLY / 2;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  cfg_t              cfg;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  pos_req_t          pos_req;
  pos_res_t          pos_res;

  // Register file for the two configuration registers.
  shd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Count table; its read data arrives the cycle after the address.
  shd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared position check and index unit, used once per extracted position.
  shd_pos_unit #(
    .SECTION_SIZE (SECTION_SIZE)
  ) u_pos (
    .req (pos_req),
    .res (pos_res)
  );

  // Sequencer: header, counts and position parsing, pending result and output register.
  shd_ctrl #(
    .MAX_POLYS      (MAX_POLYS),
    .MAX_HINT_LIMIT (MAX_HINT_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pos_req   (pos_req),
    .pos_res   (pos_res)
  );

endmodule

// ----- hdl/shd_ram.sv -----
module shd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/shd_cfg.sv -----
module shd_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [shd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output shd_pkg::cfg_t              cfg
);

  import shd_pkg::*;

  logic [3:0] num_polys_r;
  logic [7:0] max_hints_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_polys_r <= NUM_POLYS_RST;
      max_hints_r <= MAX_HINTS_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        CFG_IDX_NUM_POLYS: num_polys_r <= pwdata[3:0];
        CFG_IDX_MAX_HINTS: max_hints_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_NUM_POLYS: prdata = {28'd0, num_polys_r};
      CFG_IDX_MAX_HINTS: prdata = {24'd0, max_hints_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg.num_polys = num_polys_r;
  assign cfg.max_hints = max_hints_r;

endmodule

// ----- hdl/shd_pos_unit.sv -----
module shd_pos_unit #(
  parameter int SECTION_SIZE = shd_pkg::SECTION_SIZE_DEF
) (
  input  shd_pkg::pos_req_t req,
  output shd_pkg::pos_res_t res
);

  import shd_pkg::*;

  localparam logic [6:0] SECT7 = 7'(SECTION_SIZE);

  logic [6:0] pos7;

  assign pos7 = {1'b0, req.pos};

  // Reject: empty section, position past section end, or not increasing.
  assign res.bad = req.left_zero || (pos7 >= SECT7) || ($signed(pos7) <= req.prev);

  assign res.coeff = 8'(32'(req.sec_lo) * SECTION_SIZE + 32'(req.pos));

endmodule

// ----- hdl/shd_ctrl.sv -----
module shd_ctrl #(
  parameter int MAX_POLYS      = shd_pkg::MAX_POLYS_DEF,
  parameter int MAX_HINT_LIMIT = shd_pkg::MAX_HINT_LIMIT_DEF,
  localparam int RAM_AW = $clog2(MAX_POLYS * shd_pkg::SECS_PER_POLY / 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  shd_pkg::cfg_t     cfg,
  shd_in_if.sink            in_ch,
  shd_out_if.source         out_ch,
  output logic              ram_we,
  output logic [RAM_AW-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic [RAM_AW-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output shd_pkg::pos_req_t pos_req,
  input  shd_pkg::pos_res_t pos_res
);

  import shd_pkg::*;

  localparam int NUM_SECS = MAX_POLYS * SECS_PER_POLY;
  localparam int SEC_W    = $clog2(NUM_SECS + 1);
  localparam int SUM_W    = $clog2(15 * NUM_SECS + 1);
  localparam int CMP_W    = (SUM_W > 8) ? SUM_W : 8;

  localparam logic [3:0] NP_MAX  = 4'(MAX_POLYS);
  localparam logic [7:0] LIM_MAX = 8'(MAX_HINT_LIMIT);

  typedef enum logic [3:0] {
    PH_HEADER    = 4'b0001,
    PH_COUNTS    = 4'b0010,
    PH_POSITIONS = 4'b0100,
    PH_DONE      = 4'b1000
  } phase_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WORK  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_RDW   = 7'b0001000,
    ST_POS   = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_VERD  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [SEC_W-1:0]  used_r, used_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [13:0]       bitbuf_r, bitbuf_nxt;
  logic [3:0]        held_r, held_nxt;
  logic [SEC_W-1:0]  cs_r, cs_nxt;
  logic [3:0]        left_r, left_nxt;
  logic signed [6:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]  pl_r, pl_nxt;
  logic              err_r, err_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic              out_vld_r, out_vld_nxt;

  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic [2:0] pend_poly_r, pend_poly_nxt;
  logic [7:0] pend_coeff_r, pend_coeff_nxt;
  logic [2:0] out_poly_r;
  logic [7:0] out_coeff_r;
  logic       out_isv_r;
  logic       out_verd_r;
  logic       out_end_r;

  logic       push;
  logic [2:0] push_poly;
  logic [7:0] push_coeff;
  logic       push_isv;
  logic       push_verd;
  logic       push_end;
  logic       out_free;
  logic [3:0] np;
  logic [7:0] lim;

  assign out_free = !out_vld_r || out_ch.ready;
  assign np       = (cfg.num_polys > NP_MAX) ? NP_MAX : cfg.num_polys;
  assign lim      = (cfg.max_hints > LIM_MAX) ? LIM_MAX : cfg.max_hints;

  assign pos_req.pos       = bitbuf_r[5:0];
  assign pos_req.left_zero = (left_r == 4'd0);
  assign pos_req.prev      = prev_r;
  assign pos_req.sec_lo    = cs_r[2:0];

  assign ram_waddr = cs_r[RAM_AW:1];
  assign ram_raddr = cs_r[RAM_AW:1];
  assign ram_wdata = byte_r;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.poly_index  = out_poly_r;
  assign out_ch.coeff_index = out_coeff_r;
  assign out_ch.is_verdict  = out_isv_r;
  assign out_ch.verdict     = out_verd_r;
  assign out_ch.run_end     = out_end_r;

  always_comb begin
    logic [3:0]       lo;
    logic [3:0]       hi;
    logic [SEC_W-1:0] cs1;
    logic [SEC_W-1:0] cs2;
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum2;
    logic [SUM_W-1:0] fsum;
    logic             fin;
    logic             cerr;
    logic             go;

    state_nxt      = state_r;
    phase_nxt      = phase_r;
    used_nxt       = used_r;
    sum_nxt        = sum_r;
    bitbuf_nxt     = bitbuf_r;
    held_nxt       = held_r;
    cs_nxt         = cs_r;
    left_nxt       = left_r;
    prev_nxt       = prev_r;
    pl_nxt         = pl_r;
    err_nxt        = err_r;
    pend_vld_nxt   = pend_vld_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    pend_poly_nxt  = pend_poly_r;
    pend_coeff_nxt = pend_coeff_r;
    ram_we         = 1'b0;
    push           = 1'b0;
    push_poly      = pend_poly_r;
    push_coeff     = pend_coeff_r;
    push_isv       = 1'b0;
    push_verd      = 1'b0;
    push_end       = 1'b0;

    lo   = byte_r[3:0];
    hi   = byte_r[7:4];
    cs1  = cs_r + SEC_W'(1);
    cs2  = cs_r + SEC_W'(2);
    sum1 = sum_r + SUM_W'(lo);
    sum2 = sum1 + SUM_W'(hi);
    if (cs1 >= used_r) begin
      fin  = 1'b1;
      cerr = (lo == 4'd0) || (hi != 4'd0);
      fsum = sum1;
    end else begin
      fin  = (cs2 >= used_r);
      cerr = fin && (hi == 4'd0);
      fsum = sum2;
    end
    go = (held_r >= 4'd6) && (pl_r != '0) && !err_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          byte_nxt  = in_ch.hint_byte;
          last_nxt  = in_ch.last_byte;
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        state_nxt = ST_FLUSH;
        if (err_r) begin
          phase_nxt = PH_DONE;
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              if (byte_r > {1'b0, np, 3'b000}) begin
                err_nxt   = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                used_nxt  = SEC_W'(byte_r);
                sum_nxt   = '0;
                cs_nxt    = '0;
                phase_nxt = (byte_r != 8'd0) ? PH_COUNTS : PH_DONE;
              end
            end
            PH_COUNTS: begin
              // Store both nibbles as one row; a nibble past the last section is never read.
              ram_we  = 1'b1;
              sum_nxt = fsum;
              cs_nxt  = (cs1 >= used_r) ? cs1 : cs2;
              if (fin) begin
                if (cerr || (CMP_W'(fsum) > CMP_W'(lim))) begin
                  err_nxt   = 1'b1;
                  phase_nxt = PH_DONE;
                end else begin
                  pl_nxt     = fsum;
                  cs_nxt     = '0;
                  prev_nxt   = -7'sd1;
                  bitbuf_nxt = '0;
                  held_nxt   = '0;
                  if (fsum != '0) begin
                    phase_nxt = PH_POSITIONS;
                    state_nxt = ST_RD;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
              end
            end
            PH_POSITIONS: begin
              bitbuf_nxt = bitbuf_r | (14'(byte_r) << held_r);
              held_nxt   = held_r + 4'd8;
              state_nxt  = ST_POS;
            end
            PH_DONE: begin
              err_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        left_nxt  = cs_r[0] ? ram_rdata[7:4] : ram_rdata[3:0];
        prev_nxt  = -7'sd1;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        if (go) begin
          if ((left_r == 4'd0) && (cs1 < used_r)) begin
            cs_nxt    = cs1;
            state_nxt = ST_RD;
          end else if (pos_res.bad) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_DONE;
            state_nxt = ST_FLUSH;
          end else if (!pend_vld_r || out_free) begin
            push           = pend_vld_r;
            pend_vld_nxt   = 1'b1;
            pend_poly_nxt  = 3'(cs_r >> 3);
            pend_coeff_nxt = pos_res.coeff;
            bitbuf_nxt     = bitbuf_r >> 6;
            held_nxt       = held_r - 4'd6;
            pl_nxt         = pl_r - SUM_W'(1);
            prev_nxt       = $signed({1'b0, bitbuf_r[5:0]});
            left_nxt       = left_r - 4'd1;
          end
        end else begin
          if ((phase_r == PH_POSITIONS) && (pl_r == '0)) begin
            err_nxt   = err_r || (bitbuf_r != '0);
            phase_nxt = PH_DONE;
          end
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_vld_r) begin
          if (out_free) begin
            push         = 1'b1;
            push_end     = !last_r;
            pend_vld_nxt = 1'b0;
          end
        end else begin
          state_nxt = last_r ? ST_VERD : ST_IDLE;
        end
      end
      ST_VERD: begin
        if (out_free) begin
          push       = 1'b1;
          push_poly  = 3'd0;
          push_coeff = 8'd0;
          push_isv   = 1'b1;
          push_verd  = err_r || (phase_r != PH_DONE);
          push_end   = 1'b1;
          phase_nxt  = PH_HEADER;
          used_nxt   = '0;
          sum_nxt    = '0;
          bitbuf_nxt = '0;
          held_nxt   = '0;
          cs_nxt     = '0;
          left_nxt   = '0;
          prev_nxt   = -7'sd1;
          pl_nxt     = '0;
          err_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_vld_nxt = push ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_HEADER;
      used_r     <= '0;
      sum_r      <= '0;
      bitbuf_r   <= '0;
      held_r     <= '0;
      cs_r       <= '0;
      left_r     <= '0;
      prev_r     <= -7'sd1;
      pl_r       <= '0;
      err_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      used_r     <= used_nxt;
      sum_r      <= sum_nxt;
      bitbuf_r   <= bitbuf_nxt;
      held_r     <= held_nxt;
      cs_r       <= cs_nxt;
      left_r     <= left_nxt;
      prev_r     <= prev_nxt;
      pl_r       <= pl_nxt;
      err_r      <= err_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    last_r       <= last_nxt;
    pend_poly_r  <= pend_poly_nxt;
    pend_coeff_r <= pend_coeff_nxt;
    if (push) begin
      out_poly_r  <= push_poly;
      out_coeff_r <= push_coeff;
      out_isv_r   <= push_isv;
      out_verd_r  <= push_verd;
      out_end_r   <= push_end;
    end
  end

endmodule

// ----- hdl/shd_checker.sv -----
`include "sparse_hint_decoder_checker_macros.svh"

module shd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_poly_index,
  input logic [7:0] out_coeff_index,
  input logic       out_is_verdict,
  input logic       out_verdict,
  input logic       out_run_end
);

  // A verdict always closes the run of its byte.
  `SHD_ASSERT_IMP(a_verdict_ends_run, clk, rst_n, out_valid && out_is_verdict, out_run_end)

  // Position results never carry a failing verdict bit.
  `SHD_ASSERT_IMP(a_pos_verdict_zero, clk, rst_n, out_valid && !out_is_verdict, !out_verdict)

  // One byte at a time: no transfer in the cycle right after an accepted one.
  `SHD_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // A stalled result holds.
  `SHD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable({out_poly_index, out_coeff_index, out_is_verdict, out_verdict,
                          out_run_end}))

endmodule

bind sparse_hint_decoder_checker shd_checker u_shd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_poly_index  (out_ch.poly_index),
  .out_coeff_index (out_ch.coeff_index),
  .out_is_verdict  (out_ch.is_verdict),
  .out_verdict     (out_ch.verdict),
  .out_run_end     (out_ch.run_end)
);

// ----- test/sparse_hint_decoder_checker_tb.sv -----
`timescale 1ns / 100ps

module sparse_hint_decoder_checker_tb;

  // Run length guards: the watchdog limit is several times the slowest
  // legal run, the drain wait covers a byte that skips every empty section.
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 240;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PHASE_COUNT     = 6;
  localparam int BYTES_PER_PHASE = 20;

  typedef enum logic [1:0] {
    FP_HEADER,
    FP_COUNTS,
    FP_POSITIONS,
    FP_DONE
  } field_phase_e;

  // Ways a generated hint field is made malformed.
  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_PAD_NIBBLE,
    FLAW_ZERO_FINAL,
    FLAW_OVER_LIMIT,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_PAD_BITS,
    FLAW_POS_RANGE,
    FLAW_POS_ORDER,
    FLAW_BIT_FLIP,
    FLAW_NOISE
  } frame_flaw_e;

  typedef struct packed {
    logic [2:0] poly;
    logic [7:0] coeff;
    logic       is_verdict;
    logic       verdict;
    logic       run_end;
  } hint_result_t;

  // Decodes the hint field byte by byte and keeps the results still due
  // from the block, oldest first.
  class hint_result_book;
    logic [3:0]        num_polys;
    logic [7:0]        max_hints;
    logic [3:0]        sec_count [64];
    field_phase_e      phase;
    logic [6:0]        used_secs;
    logic [9:0]        count_sum;
    logic [13:0]       bit_buf;
    logic [3:0]        bits_held;
    logic [6:0]        cur_sec;
    logic [3:0]        left_in_sec;
    logic signed [7:0] prev_pos;
    logic [9:0]        pos_left;
    bit                bad_field;
    hint_result_t      due_results [$];

    function new();
      num_polys = shd_pkg::NUM_POLYS_RST;
      max_hints = shd_pkg::MAX_HINTS_RST;
      restart_field();
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == shd_pkg::CFG_IDX_NUM_POLYS) begin
        num_polys = value[3:0];
      end else if (idx == shd_pkg::CFG_IDX_MAX_HINTS) begin
        max_hints = value[7:0];
      end
    endfunction

    function void restart_field();
      for (int s = 0; s < 64; s++) sec_count[s] = '0;
      phase       = FP_HEADER;
      used_secs   = '0;
      count_sum   = '0;
      bit_buf     = '0;
      bits_held   = '0;
      cur_sec     = '0;
      left_in_sec = '0;
      prev_pos    = -8'sd1;
      pos_left    = '0;
      bad_field   = 1'b0;
    endfunction

    function logic [3:0] count_of(int s);
      return (s < 64) ? sec_count[s] : 4'd0;
    endfunction

    function void add_result(logic [2:0] poly, logic [7:0] coeff, logic is_v, logic v);
      hint_result_t r;
      r.poly       = poly;
      r.coeff      = coeff;
      r.is_verdict = is_v;
      r.verdict    = v;
      r.run_end    = 1'b0;
      due_results.push_back(r);
    endfunction

    function void store_count(logic [3:0] v);
      if (cur_sec < 64) sec_count[cur_sec[5:0]] = v;
      count_sum = count_sum + 10'(v);
      cur_sec   = cur_sec + 7'd1;
    endfunction

    function void close_counts();
      int lim;
      lim = (max_hints > shd_pkg::MAX_HINT_LIMIT_DEF) ? shd_pkg::MAX_HINT_LIMIT_DEF
                                                       : int'(max_hints);
      if (int'(count_sum) > lim) bad_field = 1'b1;
      if (bad_field) begin
        phase = FP_DONE;
        return;
      end
      pos_left    = count_sum;
      cur_sec     = '0;
      left_in_sec = count_of(0);
      prev_pos    = -8'sd1;
      bit_buf     = '0;
      bits_held   = '0;
      phase       = (pos_left != 0) ? FP_POSITIONS : FP_DONE;
    endfunction

    function void take_counts(logic [7:0] b);
      store_count(b[3:0]);
      if (cur_sec >= used_secs) begin
        if (b[3:0] == 4'd0 || b[7:4] != 4'd0) bad_field = 1'b1;
        close_counts();
        return;
      end
      store_count(b[7:4]);
      if (cur_sec >= used_secs) begin
        if (b[7:4] == 4'd0) bad_field = 1'b1;
        close_counts();
      end
    endfunction

    function int take_positions(logic [7:0] b);
      int         n;
      int         coeff;
      logic [5:0] p;
      n = 0;
      bit_buf   = bit_buf | (14'(b) << bits_held);
      bits_held = bits_held + 4'd8;
      while (bits_held >= 6 && pos_left != 0 && !bad_field) begin
        p         = bit_buf[5:0];
        bit_buf   = bit_buf >> 6;
        bits_held = bits_held - 4'd6;
        pos_left  = pos_left - 10'd1;
        // skip empty sections, each one restarts the ordering
        while (left_in_sec == 0 && int'(cur_sec) + 1 < int'(used_secs)) begin
          cur_sec     = cur_sec + 7'd1;
          left_in_sec = count_of(int'(cur_sec));
          prev_pos    = -8'sd1;
        end
        if (left_in_sec == 0 || p >= shd_pkg::SECTION_SIZE_DEF ||
            $signed({2'b00, p}) <= prev_pos) begin
          bad_field = 1'b1;
          break;
        end
        coeff = (int'(cur_sec) % shd_pkg::SECS_PER_POLY) * shd_pkg::SECTION_SIZE_DEF + int'(p);
        add_result(3'(int'(cur_sec) / shd_pkg::SECS_PER_POLY), coeff[7:0], 1'b0, 1'b0);
        prev_pos    = $signed({2'b00, p});
        left_in_sec = left_in_sec - 4'd1;
        n++;
      end
      if (bad_field) begin
        phase = FP_DONE;
      end else if (pos_left == 0) begin
        if (bit_buf != 0) bad_field = 1'b1;
        phase = FP_DONE;
      end
      return n;
    endfunction

    // Work out what one accepted byte causes and queue it.
    function void note_byte(logic [7:0] b, logic last);
      int           n;
      int           np;
      hint_result_t tail;
      n = 0;
      if (bad_field) begin
        phase = FP_DONE;
      end else begin
        case (phase)
          FP_HEADER: begin
            np = (num_polys > shd_pkg::MAX_POLYS_DEF) ? shd_pkg::MAX_POLYS_DEF
                                                       : int'(num_polys);
            if (int'(b) > np * shd_pkg::SECS_PER_POLY) begin
              bad_field = 1'b1;
              phase     = FP_DONE;
            end else begin
              used_secs = b[6:0];
              count_sum = '0;
              cur_sec   = '0;
              phase     = (b != 0) ? FP_COUNTS : FP_DONE;
            end
          end
          FP_COUNTS:    take_counts(b);
          FP_POSITIONS: n = take_positions(b);
          default:      bad_field = 1'b1;
        endcase
      end
      if (last) begin
        add_result(3'd0, 8'd0, 1'b1, bad_field || phase != FP_DONE);
        restart_field();
        n++;
      end
      if (n > 0) begin
        tail = due_results.pop_back();
        tail.run_end = 1'b1;
        due_results.push_back(tail);
      end
    endfunction

    function bit check_result(hint_result_t got, output string why);
      hint_result_t want;
      why = "";
      if (due_results.size() == 0) begin
        why = $sformatf("result with nothing due: poly %0d coeff %0d is_verdict %0d verdict %0d",
                        got.poly, got.coeff, got.is_verdict, got.verdict);
        return 1'b0;
      end
      want = due_results.pop_front();
      if (got.poly !== want.poly)
        why = {why, $sformatf(" poly_index %0d want %0d", got.poly, want.poly)};
      if (got.coeff !== want.coeff)
        why = {why, $sformatf(" coeff_index %0d want %0d", got.coeff, want.coeff)};
      if (got.is_verdict !== want.is_verdict)
        why = {why, $sformatf(" is_verdict %0d want %0d", got.is_verdict, want.is_verdict)};
      if (got.verdict !== want.verdict)
        why = {why, $sformatf(" verdict %0d want %0d", got.verdict, want.verdict)};
      if (got.run_end !== want.run_end)
        why = {why, $sformatf(" run_end %0d want %0d", got.run_end, want.run_end)};
      return (why == "");
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [shd_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  shd_in_if  in_ch ();
  shd_out_if out_ch ();

  sparse_hint_decoder_checker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hint_result_book book = new();

  int         mismatches    = 0;
  int         bytes_sent    = 0;
  int         gen_num_polys = 4;
  int         gen_max_hints = 80;
  bit         no_gaps       = 1'b0;
  bit         pressure_go   = 1'b0;
  logic       pressure_hold = 1'b0;
  logic [7:0] frame_bytes [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(string why);
    $display("%0t mismatch:%s", $time, why);
    mismatches++;
  endtask

  // Offer one byte after a random gap and hold it until the transfer.
  // Valid is left high on return so a back-to-back byte never drops it.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.hint_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    book.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Drop valid, then hold until every due result has come out and the
  // block has had time to finish any byte still in flight.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup phase, then access phase held until pready, then the bus goes idle before the next write.
  task automatic cfg_write(logic idx, logic [31:0] value);
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.set_reg(idx, value);
    if (idx == shd_pkg::CFG_IDX_NUM_POLYS) gen_num_polys = int'(value[3:0]);
    else gen_max_hints = int'(value[7:0]);
    @(posedge clk);
  endtask

  // Build one hint field in frame_bytes for the current register values:
  // a well-formed field with random sections, counts and positions, then
  // bent by the requested flaw.
  function automatic void make_frame(frame_flaw_e flaw);
    int np;
    int lim;
    int budget;
    int used;
    int total;
    int need;
    int p;
    int prev;
    int k;
    int bad_at;
    int acc;
    int nbits;
    bit dense;
    int cnt [64];
    np = (gen_num_polys > shd_pkg::MAX_POLYS_DEF) ? shd_pkg::MAX_POLYS_DEF : gen_num_polys;
    lim = (gen_max_hints > shd_pkg::MAX_HINT_LIMIT_DEF) ? shd_pkg::MAX_HINT_LIMIT_DEF
                                                         : gen_max_hints;
    frame_bytes.delete();
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      return;
    end
    if (flaw == FLAW_HEADER) begin
      frame_bytes.push_back(8'($urandom_range(np * shd_pkg::SECS_PER_POLY + 1, 255)));
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      return;
    end
    budget = (flaw == FLAW_OVER_LIMIT) ? lim + 1 + $urandom_range(0, 20) : lim;
    dense  = ($urandom_range(0, 9) == 0);
    if (np == 0 || budget == 0) begin
      used = 0;
    end else begin
      case ($urandom_range(0, 7))
        0:       used = 0;
        1:       used = np * shd_pkg::SECS_PER_POLY;
        default: used = $urandom_range(1, (np * shd_pkg::SECS_PER_POLY < 6) ?
                                          np * shd_pkg::SECS_PER_POLY : 6);
      endcase
    end
    for (int s = 0; s < 64; s++) cnt[s] = 0;
    total = 0;
    if (used > 0) begin
      // the final section must hold at least one position
      cnt[used-1] = $urandom_range(1, (budget < 15) ? budget : 15);
      total = cnt[used-1];
      for (int s = 0; s < used - 1; s++) begin
        if (flaw == FLAW_OVER_LIMIT) need = 15;
        else if (dense) need = $urandom_range(0, 15);
        else need = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (need > budget - total) need = budget - total;
        cnt[s] = need;
        total += need;
      end
    end
    frame_bytes.push_back(8'(used));
    for (int s = 0; s < used; s += 2)
      frame_bytes.push_back(8'(cnt[s] | (((s + 1 < used) ? cnt[s+1] : 0) << 4)));
    acc    = 0;
    nbits  = 0;
    k      = 0;
    bad_at = (total > 0) ? $urandom_range(0, total - 1) : 0;
    for (int s = 0; s < used; s++) begin
      need = cnt[s];
      prev = -1;
      // pick need distinct positions in increasing order
      for (int v = 0; v < shd_pkg::SECTION_SIZE_DEF && need > 0; v++) begin
        if ($urandom_range(0, shd_pkg::SECTION_SIZE_DEF - 1 - v) < need) begin
          p = v;
          if (k == bad_at && flaw == FLAW_POS_RANGE) p = $urandom_range(32, 63);
          if (k == bad_at && flaw == FLAW_POS_ORDER && prev >= 0) p = $urandom_range(0, prev);
          acc = acc | (p << nbits);
          nbits += 6;
          while (nbits >= 8) begin
            frame_bytes.push_back(8'(acc));
            acc = acc >> 8;
            nbits -= 8;
          end
          prev = v;
          need--;
          k++;
        end
      end
    end
    if (nbits > 0) begin
      if (flaw == FLAW_PAD_BITS) acc = acc | (1 << $urandom_range(nbits, 7));
      frame_bytes.push_back(8'(acc));
    end
    case (flaw)
      FLAW_PAD_NIBBLE: begin
        if (used % 2 == 1) begin
          k = 1 + used / 2;
          frame_bytes[k] = frame_bytes[k] | 8'($urandom_range(1, 15) << 4);
        end
      end
      FLAW_ZERO_FINAL: begin
        if (used > 0) begin
          k = 1 + (used - 1) / 2;
          if ((used - 1) % 2 == 0) frame_bytes[k] = frame_bytes[k] & 8'hf0;
          else frame_bytes[k] = frame_bytes[k] & 8'h0f;
        end
      end
      FLAW_SHORT: begin
        if (frame_bytes.size() > 1)
          repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
      end
      FLAW_LONG: begin
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      end
      FLAW_BIT_FLIP: begin
        if (frame_bytes.size() > 1) begin
          k = $urandom_range(1, frame_bytes.size() - 1);
          frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
        end
      end
      default: ;
    endcase
  endfunction

  // Result side: check each transfer, then draw how long to hold ready low
  // before the next one. The pressure hold-off overrides the draw.
  initial begin : result_sink
    hint_result_t got;
    string        why;
    int           wait_left;
    wait_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.poly       = out_ch.poly_index;
        got.coeff      = out_ch.coeff_index;
        got.is_verdict = out_ch.is_verdict;
        got.verdict    = out_ch.verdict;
        got.run_end    = out_ch.run_end;
        if (!book.check_result(got, why)) flag_mismatch(why);
        wait_left = no_gaps ? 0 : $urandom_range(0, 14);
      end
      out_ch.ready <= (wait_left == 0) && !pressure_hold;
      if (wait_left > 0) wait_left--;
    end
  end

  // Long receiver hold-off, counted here, so the block backs up into its input.
  initial begin : pressure_timer
    wait (pressure_go);
    @(posedge clk);
    pressure_hold <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    pressure_hold <= 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t timeout, %0d results still due", $time, book.pending());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int          phase_end;
    frame_flaw_e flaw;
    int          np_set [PHASE_COUNT];
    int          mh_set [PHASE_COUNT];
    np_set = '{1, 8, 15, 0, 3, 8};
    mh_set = '{0, 176, 255, 40, 12, 100};
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.hint_byte <= 8'd0;
    in_ch.last_byte <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= 32'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed fields under the reset settings.
    // zero sections: the header alone is the whole field
    frame_bytes = '{8'h00};
    send_frame();
    // more sections than the polynomials hold
    frame_bytes = '{8'h21};
    send_frame();
    // one section, one position at the top of the section
    frame_bytes = '{8'h01, 8'h01, 8'h1f};
    send_frame();
    // nonzero pad nibble after an odd count of sections
    frame_bytes = '{8'h01, 8'h11};
    send_frame();
    // final section count of zero
    frame_bytes = '{8'h02, 8'h05};
    send_frame();
    // a byte past the end of an empty field
    frame_bytes = '{8'h00, 8'hff};
    send_frame();
    // flagged byte before the positions arrive
    frame_bytes = '{8'h01, 8'h01};
    send_frame();
    // position beyond the section
    frame_bytes = '{8'h01, 8'h01, 8'h20};
    send_frame();
    // repeated position within a section
    frame_bytes = '{8'h01, 8'h02, 8'h45, 8'h01};
    send_frame();
    // nonzero pad bits after the last position
    frame_bytes = '{8'h01, 8'h01, 8'h43};
    send_frame();
    // two empty sections skipped before the only position
    frame_bytes = '{8'h03, 8'h00, 8'h01, 8'h1f};
    send_frame();

    // Random fields, one register setting per phase.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      cfg_write(shd_pkg::CFG_IDX_NUM_POLYS, 32'(np_set[ph]));
      cfg_write(shd_pkg::CFG_IDX_MAX_HINTS, 32'(mh_set[ph]));
      if (ph == 1) begin
        // stall the result side and keep the input busy
        pressure_go = 1'b1;
        no_gaps     = 1'b1;
        repeat (6) begin
          make_frame(FLAW_NONE);
          send_frame();
        end
      end
      phase_end = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < phase_end) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : frame_flaw_e'($urandom_range(1, 11));
        make_frame(flaw);
        send_frame();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
